[hw/rtl/fat12w_pkg.sv]
// Shared types and constants for the FAT12 cluster chain walker.
package fat12w_pkg;

  localparam int FAT_BYTES_DEF = 8192;
  localparam int MAX_RUN_DEF   = 64;

  localparam logic [11:0] EOC_MIN = 12'hFF8;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_CONT  = 2'd2;

  localparam logic [2:0] REG_RESERVED  = 3'd0;
  localparam logic [2:0] REG_PER_FAT   = 3'd1;
  localparam logic [2:0] REG_COPIES    = 3'd2;
  localparam logic [2:0] REG_ROOT      = 3'd3;
  localparam logic [2:0] REG_SECT_SIZE = 3'd4;
  localparam logic [2:0] REG_CLUS_SECT = 3'd5;

  // root directory sector divider widths
  localparam int NUM_W = 22;
  localparam int DEN_W = 13;
  localparam int DCNT_W = 5;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [12:0] table_addr;
    logic [7:0]  table_byte;
    logic [11:0] first_cluster;
    logic [31:0] file_bytes;
  } cmd_t;

  typedef struct packed {
    logic [31:0] sector_lba;
    logic [19:0] byte_count;
    logic [31:0] dest_offset;
    logic        last;
    logic        more_follows;
    logic        bad_cluster;
  } res_t;

  typedef struct packed {
    logic        go;
    logic        cont;
    logic [11:0] first_cluster;
    logic [31:0] file_bytes;
  } walk_req_t;

  typedef struct packed {
    logic [31:0] data_start;
    logic [19:0] csize;
    logic [7:0]  cluster_sectors;
  } geom_t;

endpackage

[hw/rtl/fat12w_div.sv]
// Restoring divider, one quotient bit per cycle, for the root directory sector count.
module fat12w_div
  import fat12w_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  logic [DEN_W-1:0]  rem;
  logic [DCNT_W-1:0] cnt;
  logic [DEN_W:0]    trial;
  logic              fits;

  assign trial = {rem, quot[NUM_W-1]};
  assign fits  = (trial >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DCNT_W'(NUM_W - 1);
        rem  <= '0;
        quot <= num;
      end else if (busy) begin
        quot <= {quot[NUM_W-2:0], fits};
        if (fits) begin
          rem <= DEN_W'(trial - {1'b0, den});
        end else begin
          rem <= trial[DEN_W-1:0];
        end
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

endmodule

[hw/rtl/fat12w_ram.sv]
// FAT byte store: one write port, one registered read port.
module fat12w_ram
  import fat12w_pkg::*;
#(
  parameter int DEPTH = FAT_BYTES_DEF,
  parameter int AW    = $clog2(FAT_BYTES_DEF)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/fat12w_walk.sv]
// Chain walk sequencer: result arithmetic, FAT index reduction and entry decode.
module fat12w_walk
  import fat12w_pkg::*;
#(
  parameter int FAT_BYTES = FAT_BYTES_DEF,
  parameter int MAX_RUN   = MAX_RUN_DEF,
  parameter int AW        = $clog2(FAT_BYTES_DEF)
) (
  input  logic          clk,
  input  logic          rst,
  input  walk_req_t     req,
  input  geom_t         geom,
  output logic          busy,
  output logic [AW-1:0] raddr,
  input  logic [7:0]    rdata,
  output logic          strobe,
  output res_t          result
);

  localparam int IW    = 13;
  localparam int SH    = 26;
  localparam int RECIP = (2 ** SH) / FAT_BYTES + 1;
  localparam int RW    = $clog2(RECIP + 1);
  localparam int NW    = $clog2(MAX_RUN + 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CHECK = 7'b0000010,
    S_MOD1  = 7'b0000100,
    S_MOD2  = 7'b0001000,
    S_RDLO  = 7'b0010000,
    S_RDHI  = 7'b0100000,
    S_NEXT  = 7'b1000000
  } state_t;

  state_t state;

  logic [11:0]    cur;
  logic [31:0]    bytes_left;
  logic [31:0]    write_offset;
  logic [NW-1:0]  run;
  logic [IW-1:0]  idx;
  logic [IW-1:0]  quo;
  logic [AW-1:0]  lo_addr;
  logic [AW-1:0]  hi_addr;
  logic [7:0]     lo_byte;
  logic [31:0]    held_lba;
  logic [19:0]    held_cnt;
  logic [31:0]    held_off;

  logic [19:0]       cnt;
  logic [19:0]       clus_off;
  logic [IW+RW-1:0]  prod;
  logic [IW-1:0]     qf;
  logic [15:0]       word;
  logic [11:0]       nxt;
  logic              walk_done;
  logic              cap_hit;
  logic [NW-1:0]     run_next;

  assign busy = (state != S_IDLE);

  assign cnt      = (32'(geom.csize) < bytes_left) ? geom.csize : bytes_left[19:0];
  assign clus_off = 20'(cur - 12'd2) * 20'(geom.cluster_sectors);
  assign prod     = (IW + RW)'(idx) * (IW + RW)'(RECIP);
  assign qf       = IW'(32'(quo) * FAT_BYTES);
  assign hi_addr  = (lo_addr == AW'(FAT_BYTES - 1)) ? '0 : AW'(lo_addr + 1'b1);
  assign raddr    = (state == S_RDHI) ? hi_addr : lo_addr;

  assign word      = {rdata, lo_byte};
  assign nxt       = cur[0] ? word[15:4] : word[11:0];
  assign walk_done = (bytes_left == '0) || (nxt >= EOC_MIN);
  assign run_next  = run + 1'b1;
  assign cap_hit   = (run_next == NW'(MAX_RUN));

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      strobe       <= 1'b0;
      cur          <= '0;
      bytes_left   <= '0;
      write_offset <= '0;
      run          <= '0;
    end else begin
      strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req.go) begin
            run   <= '0;
            state <= S_CHECK;
            if (!req.cont) begin
              cur          <= req.first_cluster;
              bytes_left   <= req.file_bytes;
              write_offset <= '0;
            end
          end
        end
        S_CHECK: begin
          if (bytes_left == '0 || cur >= EOC_MIN) begin
            // nothing to walk: one empty result
            strobe <= 1'b1;
            result <= '{sector_lba: '0, byte_count: '0, dest_offset: write_offset,
                        last: 1'b1, more_follows: 1'b0, bad_cluster: 1'b0};
            state  <= S_IDLE;
          end else if (cur < 12'd2) begin
            strobe     <= 1'b1;
            result     <= '{sector_lba: '0, byte_count: '0, dest_offset: write_offset,
                            last: 1'b1, more_follows: 1'b0, bad_cluster: 1'b1};
            bytes_left <= '0;
            state      <= S_IDLE;
          end else begin
            held_lba     <= geom.data_start + 32'(clus_off);
            held_cnt     <= cnt;
            held_off     <= write_offset;
            write_offset <= write_offset + 32'(cnt);
            bytes_left   <= bytes_left - 32'(cnt);
            idx          <= IW'(cur) + IW'(cur[11:1]);
            state        <= S_MOD1;
          end
        end
        S_MOD1: begin
          quo   <= IW'(prod >> SH);
          state <= S_MOD2;
        end
        S_MOD2: begin
          lo_addr <= AW'(idx - qf);
          state   <= S_RDLO;
        end
        S_RDLO: begin
          state <= S_RDHI;
        end
        S_RDHI: begin
          lo_byte <= rdata;
          state   <= S_NEXT;
        end
        S_NEXT: begin
          // the next entry, the bytes left and the run cap decide whether this result closes the item
          strobe <= 1'b1;
          result <= '{sector_lba: held_lba, byte_count: held_cnt, dest_offset: held_off,
                      last: walk_done || cap_hit, more_follows: !walk_done && cap_hit,
                      bad_cluster: 1'b0};
          cur    <= nxt;
          run    <= run_next;
          if (walk_done || cap_hit) begin
            state <= S_IDLE;
          end else begin
            state <= S_CHECK;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[hw/rtl/fat12_cluster_chain_walker.sv]
// FAT12 cluster chain walker top level: command port, configuration and data-area start.
//
// Write commands (opcode 0) store one FAT byte and finish in the cycle they are
// taken. A start or continue command walks the chain one cluster at a time: each
// cluster passes the check, the two index-reduction states and the two reads of
// the single FAT read port, then its result. Each result is shown for exactly one
// cycle with strobe high and must be captured then: the receiver cannot hold
// results off. A configuration write to one of the six registers starts the
// divider that recomputes the data-area start and the cluster size; busy stays
// high until it finishes.
module fat12_cluster_chain_walker
  import fat12w_pkg::*;
#(
  parameter int FAT_BYTES = FAT_BYTES_DEF,
  parameter int MAX_RUN   = MAX_RUN_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  cmd_t        cmd,
  output logic        strobe,
  output res_t        result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int AW = $clog2(FAT_BYTES);

  logic [15:0] reserved_sectors;
  logic [15:0] sectors_per_fat;
  logic [2:0]  fat_copies;
  logic [15:0] root_entries;
  logic [12:0] sector_bytes;
  logic [7:0]  cluster_sectors;
  logic [31:0] data_start;
  logic [19:0] csize;
  logic        recalc;

  logic             accept;
  logic             cfg_wr;
  logic             div_busy;
  logic             div_done;
  logic [NUM_W-1:0] quot;
  logic [NUM_W-1:0] num;
  logic [18:0]      fat_secs;
  logic [20:0]      csize_full;
  logic             walk_busy;
  walk_req_t        req;
  geom_t            geom;
  logic [AW-1:0]    raddr;
  logic [7:0]       rdata;
  logic             ram_we;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign busy      = walk_busy || div_busy || recalc;
  assign accept    = start && !busy;

  assign ram_we = accept && (cmd.opcode == OP_WRITE) && (32'(cmd.table_addr) < FAT_BYTES);

  assign req.go            = accept && (cmd.opcode == OP_START || cmd.opcode == OP_CONT);
  assign req.cont          = (cmd.opcode == OP_CONT);
  assign req.first_cluster = cmd.first_cluster;
  assign req.file_bytes    = cmd.file_bytes;

  assign geom.data_start      = data_start;
  assign geom.csize           = csize;
  assign geom.cluster_sectors = cluster_sectors;

  assign num        = NUM_W'({root_entries, 5'b0}) + NUM_W'(sector_bytes) - NUM_W'(1);
  assign fat_secs   = 19'(sectors_per_fat) * 19'(fat_copies);
  assign csize_full = 21'(sector_bytes) * 21'(cluster_sectors);

  always_ff @(posedge clk) begin
    if (rst) begin
      reserved_sectors <= 16'd1;
      sectors_per_fat  <= 16'd9;
      fat_copies       <= 3'd2;
      root_entries     <= 16'd224;
      sector_bytes     <= 13'd512;
      cluster_sectors  <= 8'd1;
      data_start       <= 32'd33;
      csize            <= 20'd512;
      recalc           <= 1'b0;
    end else begin
      recalc <= 1'b0;
      if (cfg_wr) begin
        recalc <= 1'b1;
        case (cfg_index)
          REG_RESERVED:  reserved_sectors <= cfg_data;
          REG_PER_FAT:   sectors_per_fat  <= cfg_data;
          REG_COPIES:    fat_copies       <= cfg_data[2:0];
          REG_ROOT:      root_entries     <= cfg_data;
          REG_SECT_SIZE: sector_bytes     <= cfg_data[12:0];
          REG_CLUS_SECT: cluster_sectors  <= cfg_data[7:0];
          default:       recalc           <= 1'b0;
        endcase
      end
      if (div_done) begin
        // a zero sector size counts as no root directory sectors
        data_start <= 32'(reserved_sectors) + 32'(fat_secs)
                    + ((sector_bytes == '0) ? 32'd0 : 32'(quot));
        csize      <= (csize_full > 21'hFFFFF) ? 20'hFFFFF : csize_full[19:0];
      end
    end
  end

  fat12w_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (recalc),
    .num   (num),
    .den   (sector_bytes),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (quot)
  );

  fat12w_ram #(
    .DEPTH (FAT_BYTES),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cmd.table_addr[AW-1:0]),
    .wdata (cmd.table_byte),
    .raddr (raddr),
    .rdata (rdata)
  );

  fat12w_walk #(
    .FAT_BYTES (FAT_BYTES),
    .MAX_RUN   (MAX_RUN),
    .AW        (AW)
  ) u_walk (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .geom   (geom),
    .busy   (walk_busy),
    .raddr  (raddr),
    .rdata  (rdata),
    .strobe (strobe),
    .result (result)
  );

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for the FAT12 cluster chain walker top level.
`timescale 1ns / 100ps

module tb;
  import fat12w_pkg::*;

  localparam logic [1:0]  OP_NONE      = 2'd3;
  localparam logic [2:0]  REG_SPARE_LO = 3'd6;
  localparam logic [2:0]  REG_SPARE_HI = 3'd7;
  localparam logic [11:0] EOC_MARK     = 12'hFFF;
  localparam logic [11:0] LAST_DATA    = 12'hFF7;
  localparam int          SETTLE_CYC   = 10;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  cmd_t        cmd;
  logic        strobe;
  res_t        result;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  // shadow of the block: geometry registers, FAT image and walk position
  logic [15:0] r_reserved;
  logic [15:0] r_per_fat;
  logic [2:0]  r_copies;
  logic [15:0] r_root;
  logic [12:0] r_sect;
  logic [7:0]  r_clus;
  logic [31:0] data_start;
  logic [7:0]  fat_img [0:FAT_BYTES_DEF-1];
  logic [11:0] cur_clus;
  logic [31:0] bytes_left;
  logic [31:0] wr_off;
  logic        chain_capped;

  res_t pending_extents[$];
  res_t want_ext;
  int   mismatches;
  int   walks;
  int   idle_pct;

  fat12_cluster_chain_walker u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .strobe    (strobe),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic [31:0] data_area_start();
    logic [31:0] dir_secs;
    logic [31:0] sb;
    sb = {19'd0, r_sect};
    dir_secs = 32'd0;
    if (sb != 32'd0) begin
      dir_secs = ({16'd0, r_root} * 32'd32 + sb - 32'd1) / sb;
    end
    return {16'd0, r_reserved} + {16'd0, r_per_fat} * {29'd0, r_copies} + dir_secs;
  endfunction

  function automatic logic [31:0] cluster_bytes();
    logic [31:0] prod;
    prod = {19'd0, r_sect} * {24'd0, r_clus};
    return (prod > 32'hFFFFF) ? 32'hFFFFF : prod;
  endfunction

  function automatic logic [11:0] fat_entry(input logic [11:0] clus);
    logic [12:0] idx;
    logic [15:0] word;
    idx = {1'b0, clus} + {2'b0, clus[11:1]};
    word = {fat_img[idx + 13'd1], fat_img[idx]};
    return clus[0] ? word[15:4] : word[11:0];
  endfunction

  // work out the extents one start or continue item produces
  task automatic trace_chain();
    res_t        batch[$];
    res_t        r;
    logic [31:0] csize;
    logic [31:0] cnt;
    logic        done;
    csize = cluster_bytes();
    chain_capped = 1'b0;
    done = 1'b0;
    while (!done) begin
      if (bytes_left == 32'd0 || cur_clus >= EOC_MIN) begin
        if (batch.size() == 0) begin
          r = '0;
          r.dest_offset = wr_off;
        end else begin
          r = batch.pop_back();
        end
        r.last = 1'b1;
        batch.push_back(r);
        done = 1'b1;
      end else if (batch.size() == MAX_RUN_DEF) begin
        r = batch.pop_back();
        r.last = 1'b1;
        r.more_follows = 1'b1;
        batch.push_back(r);
        chain_capped = 1'b1;
        done = 1'b1;
      end else if (cur_clus < 12'd2) begin
        r = '0;
        r.dest_offset = wr_off;
        r.last = 1'b1;
        r.bad_cluster = 1'b1;
        batch.push_back(r);
        bytes_left = 32'd0;
        done = 1'b1;
      end else begin
        cnt = (csize < bytes_left) ? csize : bytes_left;
        r = '0;
        r.sector_lba = data_start + ({20'd0, cur_clus} - 32'd2) * {24'd0, r_clus};
        r.byte_count = cnt[19:0];
        r.dest_offset = wr_off;
        batch.push_back(r);
        wr_off = wr_off + cnt;
        bytes_left = bytes_left - cnt;
        cur_clus = fat_entry(cur_clus);
      end
    end
    foreach (batch[i]) pending_extents.push_back(batch[i]);
  endtask

  task automatic predict_item(input cmd_t c);
    case (c.opcode)
      OP_WRITE: fat_img[c.table_addr] = c.table_byte;
      OP_START: begin
        cur_clus = c.first_cluster;
        bytes_left = c.file_bytes;
        wr_off = 32'd0;
        trace_chain();
      end
      OP_CONT: trace_chain();
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (pending_extents.size() == 0) begin
        $display("%0t: extent with none expected: expected nothing, got %h", $time, result);
        mismatches++;
      end else begin
        want_ext = pending_extents.pop_front();
        if (result.sector_lba !== want_ext.sector_lba) begin
          $display("%0t: sector_lba expected %h got %h", $time,
                   want_ext.sector_lba, result.sector_lba);
          mismatches++;
        end
        if (result.byte_count !== want_ext.byte_count) begin
          $display("%0t: byte_count expected %h got %h", $time,
                   want_ext.byte_count, result.byte_count);
          mismatches++;
        end
        if (result.dest_offset !== want_ext.dest_offset) begin
          $display("%0t: dest_offset expected %h got %h", $time,
                   want_ext.dest_offset, result.dest_offset);
          mismatches++;
        end
        if (result.last !== want_ext.last) begin
          $display("%0t: last expected %b got %b", $time, want_ext.last, result.last);
          mismatches++;
        end
        if (result.more_follows !== want_ext.more_follows) begin
          $display("%0t: more_follows expected %b got %b", $time,
                   want_ext.more_follows, result.more_follows);
          mismatches++;
        end
        if (result.bad_cluster !== want_ext.bad_cluster) begin
          $display("%0t: bad_cluster expected %b got %b", $time,
                   want_ext.bad_cluster, result.bad_cluster);
          mismatches++;
        end
      end
    end
  end

  // leaves start high so back-to-back items need no gap
  task automatic send_cmd(input cmd_t c);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (busy);
    predict_item(c);
  endtask

  function automatic cmd_t noise_cmd(input logic [1:0] op);
    cmd_t c;
    c = {$urandom, $urandom, $urandom};
    c.opcode = op;
    return c;
  endfunction

  task automatic send_write(input logic [12:0] addr, input logic [7:0] val);
    cmd_t c;
    c = noise_cmd(OP_WRITE);
    c.table_addr = addr;
    c.table_byte = val;
    send_cmd(c);
  endtask

  task automatic send_start(input logic [11:0] clus, input logic [31:0] size);
    cmd_t c;
    c = noise_cmd(OP_START);
    c.first_cluster = clus;
    c.file_bytes = size;
    walks++;
    send_cmd(c);
  endtask

  task automatic send_cont();
    walks++;
    send_cmd(noise_cmd(OP_CONT));
  endtask

  // rewrite one 12-bit entry, keeping the neighbor's nibble
  task automatic set_entry(input logic [11:0] clus, input logic [11:0] val);
    logic [12:0] idx;
    logic [7:0]  lo;
    logic [7:0]  hi;
    idx = {1'b0, clus} + {2'b0, clus[11:1]};
    lo = fat_img[idx];
    hi = fat_img[idx + 13'd1];
    if (clus[0]) begin
      lo = {val[3:0], lo[3:0]};
      hi = val[11:4];
    end else begin
      lo = val[7:0];
      hi = {hi[7:4], val[11:8]};
    end
    send_write(idx, lo);
    send_write(idx + 13'd1, hi);
  endtask

  // drop start, drain results and let the block go idle
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (pending_extents.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_RESERVED:  r_reserved = val;
      REG_PER_FAT:   r_per_fat = val;
      REG_COPIES:    r_copies = val[2:0];
      REG_ROOT:      r_root = val;
      REG_SECT_SIZE: r_sect = val[12:0];
      REG_CLUS_SECT: r_clus = val[7:0];
      default: ;
    endcase
    data_start = data_area_start();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // junk above the copies, sector size and cluster registers' widths must be dropped
  task automatic set_geometry(input logic [15:0] rsv, input logic [15:0] pf,
                              input logic [2:0] cp, input logic [15:0] re,
                              input logic [12:0] sb, input logic [7:0] cs);
    logic [15:0] junk;
    junk = $urandom;
    settle();
    write_reg(REG_RESERVED, rsv);
    write_reg(REG_PER_FAT, pf);
    write_reg(REG_COPIES, {junk[12:0], cp});
    write_reg(REG_ROOT, re);
    write_reg(REG_SECT_SIZE, {junk[2:0], sb});
    write_reg(REG_CLUS_SECT, {junk[7:0], cs});
  endtask

  task automatic probe_geometry();
    send_start(12'd2, 32'hFFFF_FFFF);
    send_start(12'd6, $urandom);
    send_start(12'd100, $urandom_range(0, 70000));
    send_cont();
  endtask

  // every entry gets written so no walk reads an unwritten byte
  task automatic test_fat_fill();
    for (int a = 0; a < FAT_BYTES_DEF; a++) send_write(a[12:0], $urandom);
  endtask

  task automatic test_walk_cases();
    set_entry(12'd2, 12'd3);
    set_entry(12'd3, EOC_MARK);
    send_start(12'd2, 32'hFFFF_FFFF);
    send_start(12'd2, 32'd700);
    send_cont();
    send_start(12'd2, 32'd0);
    send_start(EOC_MARK, 32'd100);
    send_start(EOC_MIN, 32'd100);
    send_start(12'd0, 32'd100);
    send_start(12'd1, 32'd100);
    set_entry(12'd4, 12'd5);
    set_entry(12'd5, 12'd1);
    send_start(12'd4, 32'd5000);
    set_entry(12'd8, 12'd0);
    send_start(12'd8, 32'd1);
    set_entry(LAST_DATA, EOC_MIN);
    send_start(LAST_DATA, 32'd1);
    send_cmd(noise_cmd(OP_NONE));
    send_cont();
  endtask

  task automatic test_cap_and_continue();
    set_entry(12'd6, 12'd6);
    send_start(12'd6, 32'hFFFF_FFFF);
    send_cont();
    send_start(12'd6, 32'd64 * 32'd512);
    send_cont();
    for (int i = 100; i < 163; i++) set_entry(i[11:0], i[11:0] + 12'd1);
    set_entry(12'd163, EOC_MARK);
    send_start(12'd100, 32'hFFFF_FFFF);
    set_entry(12'd163, 12'd164);
    set_entry(12'd164, EOC_MARK);
    send_start(12'd100, 32'hFFFF_FFFF);
    send_cont();
  endtask

  task automatic test_register_settings();
    set_geometry(16'd0, 16'd0, 3'd1, 16'd0, 13'd1, 8'd1);
    probe_geometry();
    set_geometry(16'hFFFF, 16'hFFFF, 3'd4, 16'hFFFF, 13'd4096, 8'd128);
    probe_geometry();
    set_geometry(16'hFFFF, 16'hFFFF, 3'd7, 16'hFFFF, 13'd1, 8'd255);
    probe_geometry();
    // sector size zero: no root directory sectors, zero-length extents
    set_geometry(16'd3, 16'd5, 3'd0, 16'd100, 13'd0, 8'd4);
    probe_geometry();
    set_geometry(16'd1, 16'd9, 3'd2, 16'd224, 13'd512, 8'd0);
    probe_geometry();
    // cluster size saturates at 20 bits
    set_geometry(16'd1, 16'd9, 3'd2, 16'd224, 13'd8191, 8'd255);
    probe_geometry();
    settle();
    write_reg(REG_SPARE_LO, $urandom);
    write_reg(REG_SPARE_HI, $urandom);
    probe_geometry();
    set_geometry(16'd1, 16'd9, 3'd2, 16'd224, 13'd512, 8'd1);
  endtask

  task automatic walk_new_chain();
    logic [11:0] head;
    logic [11:0] clus;
    logic [11:0] nxt;
    logic [31:0] span;
    logic [31:0] size;
    int          len;
    int          sel;
    len = $urandom_range(1, 80);
    head = $urandom_range(2, LAST_DATA);
    clus = head;
    repeat (len - 1) begin
      nxt = $urandom_range(2, LAST_DATA);
      set_entry(clus, nxt);
      clus = nxt;
    end
    sel = $urandom_range(0, 99);
    if (sel < 70) set_entry(clus, $urandom_range(EOC_MIN, EOC_MARK));
    else if (sel < 85) set_entry(clus, $urandom_range(0, 1));
    else set_entry(clus, head);
    span = len * cluster_bytes();
    sel = $urandom_range(0, 99);
    if (sel < 35) size = $urandom;
    else if (sel < 80) size = $urandom_range(0, span + span / 4);
    else size = span;
    send_start(head, size);
    while (chain_capped && $urandom_range(0, 99) < 80) send_cont();
  endtask

  task automatic test_random_walks();
    int          goal;
    int          sel;
    logic [11:0] clus;
    for (int ph = 0; ph < 6; ph++) begin
      idle_pct = (ph < 2) ? 9 : ((ph < 4) ? 67 : 0);
      if (ph == 5) begin
        set_geometry(16'd1, 16'd9, 3'd2, 16'd224, 13'd512, 8'd1);
      end else begin
        set_geometry($urandom, $urandom, $urandom_range(1, 4), $urandom,
                     $urandom_range(1, 4096), $urandom_range(1, 128));
      end
      goal = walks + 34;
      while (walks < goal) begin
        sel = $urandom_range(0, 99);
        if (sel < 55) begin
          walk_new_chain();
        end else if (sel < 70) begin
          send_start($urandom, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 20000));
        end else if (sel < 78) begin
          send_cont();
        end else if (sel < 88) begin
          repeat ($urandom_range(1, 6)) send_write($urandom, $urandom);
        end else if (sel < 92) begin
          send_cmd(noise_cmd(OP_NONE));
        end else begin
          // broken chain: point an entry at a free or reserved cluster
          clus = $urandom_range(2, LAST_DATA);
          set_entry(clus, $urandom_range(0, 1));
          send_start(clus, $urandom);
        end
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    cmd = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_RESERVED;
    cfg_data = 16'd0;
    r_reserved = 16'd1;
    r_per_fat = 16'd9;
    r_copies = 3'd2;
    r_root = 16'd224;
    r_sect = 13'd512;
    r_clus = 8'd1;
    data_start = data_area_start();
    cur_clus = 12'd0;
    bytes_left = 32'd0;
    wr_off = 32'd0;
    chain_capped = 1'b0;
    mismatches = 0;
    walks = 0;
    idle_pct = 9;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_fat_fill();
    test_walk_cases();
    test_cap_and_continue();
    test_register_settings();
    test_random_walks();
    settle();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
